>>> rtl/gse_pkg.sv
// types, constants and gcr table for the sector gcr encoder
package gse_pkg;

  localparam logic [1:0] CMD_HEAD  = 2'd0;
  localparam logic [1:0] CMD_GROUP = 2'd1;
  localparam logic [1:0] CMD_TAIL  = 2'd2;

  localparam logic REG_DISK_ID_FIRST  = 1'b0;
  localparam logic REG_DISK_ID_SECOND = 1'b1;

  localparam logic [7:0] SYNC_BYTE   = 8'hff;
  localparam logic [7:0] GAP_BYTE    = 8'h55;
  localparam logic [7:0] HEADER_MARK = 8'h08;
  localparam logic [7:0] DATA_MARK   = 8'h07;
  localparam logic [7:0] HEADER_PAD  = 8'h0f;

  localparam logic [4:0] HEAD_LAST  = 5'd28;
  localparam logic [4:0] GROUP_LAST = 5'd4;
  localparam logic [4:0] TAIL_LAST  = 5'd10;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
  } cmd_t;

  function automatic logic [4:0] gcr_code(input logic [3:0] nib);
    logic [4:0] code;
    case (nib)
      4'h0: code = 5'h0a;
      4'h1: code = 5'h0b;
      4'h2: code = 5'h12;
      4'h3: code = 5'h13;
      4'h4: code = 5'h0e;
      4'h5: code = 5'h0f;
      4'h6: code = 5'h16;
      4'h7: code = 5'h17;
      4'h8: code = 5'h09;
      4'h9: code = 5'h19;
      4'ha: code = 5'h1a;
      4'hb: code = 5'h1b;
      4'hc: code = 5'h0d;
      4'hd: code = 5'h1d;
      4'he: code = 5'h1e;
      default: code = 5'h15;
    endcase
    return code;
  endfunction

  function automatic logic [39:0] gcr_group(input logic [7:0] b0, input logic [7:0] b1,
                                            input logic [7:0] b2, input logic [7:0] b3);
    return {gcr_code(b0[7:4]), gcr_code(b0[3:0]), gcr_code(b1[7:4]), gcr_code(b1[3:0]),
            gcr_code(b2[7:4]), gcr_code(b2[3:0]), gcr_code(b3[7:4]), gcr_code(b3[3:0])};
  endfunction

endpackage

>>> rtl/gse_front.sv
// front end: id registers, sector position, checksum and group assembly
module gse_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [7:0]     cfg_data,
  input  logic           accept,
  input  logic [7:0]     data_byte,
  input  logic [5:0]     track_number,
  input  logic [4:0]     sector_number,
  output logic           cmd_valid,
  output gse_pkg::cmd_t  cmd
);
  import gse_pkg::*;

  logic [7:0] disk_id_first;
  logic [7:0] disk_id_second;
  logic [7:0] byte_position;
  logic [7:0] data_checksum;
  logic [7:0] pend0;
  logic [7:0] pend1;
  logic [7:0] pend2;
  logic [1:0] slot;
  logic [7:0] sec8;
  logic [7:0] trk8;
  logic [7:0] chk_next;

  assign slot     = byte_position[1:0] + 2'd1;
  assign sec8     = {3'b000, sector_number};
  assign trk8     = {2'b00, track_number};
  assign chk_next = (byte_position == 8'd0) ? data_byte : (data_checksum ^ data_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      disk_id_first  <= '0;
      disk_id_second <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_DISK_ID_FIRST) begin
        disk_id_first <= cfg_data;
      end else begin
        disk_id_second <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      data_checksum <= '0;
      pend0         <= '0;
      pend1         <= '0;
      pend2         <= '0;
    end else if (accept) begin
      byte_position <= byte_position + 8'd1;
      data_checksum <= chk_next;
      if (byte_position == 8'd0) begin
        pend0 <= DATA_MARK;
      end
      if (byte_position != 8'd255) begin
        case (slot)
          2'd0: pend0 <= data_byte;
          2'd1: pend1 <= data_byte;
          2'd2: pend2 <= data_byte;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    cmd_valid = 1'b0;
    cmd       = '{kind: CMD_GROUP, b0: pend0, b1: pend1, b2: pend2, b3: data_byte};
    if (byte_position == 8'd0) begin
      cmd_valid = accept;
      cmd       = '{kind: CMD_HEAD, b0: sec8, b1: trk8, b2: disk_id_second,
                    b3: disk_id_first};
    end else if (byte_position == 8'd255) begin
      cmd_valid = accept;
      cmd       = '{kind: CMD_TAIL, b0: data_byte, b1: chk_next, b2: 8'h00, b3: 8'h00};
    end else if (slot == 2'd3) begin
      cmd_valid = accept;
    end
  end

endmodule

>>> rtl/gse_cmd_fifo.sv
// short command queue between front and back end
module gse_cmd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  gse_pkg::cmd_t  wr_data,
  output logic           full,
  input  logic           rd_en,
  output gse_pkg::cmd_t  rd_data,
  output logic           empty
);
  import gse_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  cmd_t          entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

>>> rtl/gse_back.sv
// back end: byte sequencer with gcr encoding and output register
module gse_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_empty,
  input  gse_pkg::cmd_t  cmd_head,
  output logic           cmd_pop,
  input  logic           pop,
  output logic           empty,
  output logic [7:0]     gcr_byte,
  output logic           run_last,
  output logic           sector_done
);
  import gse_pkg::*;

  cmd_t        cur;
  logic        active;
  logic [4:0]  step;
  logic        ovalid;
  logic        advance;
  logic        is_last;
  logic [4:0]  last_step;
  logic [4:0]  gidx;
  logic        use_group;
  logic [7:0]  g0;
  logic [7:0]  g1;
  logic [7:0]  g2;
  logic [7:0]  g3;
  logic [7:0]  fill_byte;
  logic [39:0] bits;
  logic [7:0]  byte_next;

  assign empty   = !ovalid;
  assign advance = active && (!ovalid || pop);
  assign is_last = (step == last_step);
  assign cmd_pop = !cmd_empty && (!active || (advance && is_last));

  always_comb begin
    last_step = GROUP_LAST;
    gidx      = step;
    use_group = 1'b1;
    fill_byte = GAP_BYTE;
    g0        = cur.b0;
    g1        = cur.b1;
    g2        = cur.b2;
    g3        = cur.b3;
    case (cur.kind)
      CMD_HEAD: begin
        last_step = HEAD_LAST;
        if (step < 5'd10) begin
          gidx = step - 5'd5;
          g0   = HEADER_MARK;
          g1   = cur.b0 ^ cur.b1 ^ cur.b2 ^ cur.b3;
          g2   = cur.b0;
          g3   = cur.b1;
        end else begin
          gidx = step - 5'd10;
          g0   = cur.b2;
          g1   = cur.b3;
          g2   = HEADER_PAD;
          g3   = HEADER_PAD;
        end
        use_group = (step >= 5'd5) && (step < 5'd15);
        fill_byte = ((step < 5'd5) || (step >= 5'd24)) ? SYNC_BYTE : GAP_BYTE;
      end
      CMD_TAIL: begin
        last_step = TAIL_LAST;
        use_group = (step < 5'd5);
      end
      default: ;
    endcase
  end

  assign bits = gcr_group(g0, g1, g2, g3);

  always_comb begin
    case (gidx[2:0])
      3'd0:    byte_next = bits[39:32];
      3'd1:    byte_next = bits[31:24];
      3'd2:    byte_next = bits[23:16];
      3'd3:    byte_next = bits[15:8];
      default: byte_next = bits[7:0];
    endcase
    if (!use_group) begin
      byte_next = fill_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      step   <= '0;
    end else if (cmd_pop) begin
      active <= 1'b1;
      step   <= '0;
    end else if (advance) begin
      if (is_last) begin
        active <= 1'b0;
      end
      step <= step + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd_head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (advance) begin
      ovalid <= 1'b1;
    end else if (pop) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      gcr_byte    <= byte_next;
      run_last    <= is_last;
      sector_done <= is_last && (cur.kind == CMD_TAIL);
    end
  end

endmodule

>>> rtl/gcr_sector_encoder_top.sv
// top level of the sector gcr image encoder
// path: an input transfer is written into the command queue, popped into the back end and registered as a result byte
// throughput: one result byte per cycle while pop is held; inputs one per cycle while the command queue has room,
// the sustained input rate is set by the single output byte per cycle of the back end
// reset: position, checksum, disk ids, command queue, back end sequencer and output valid flag cleared
module gcr_sector_encoder_top #(
  parameter int CMD_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte,
  input  logic [5:0] track_number,
  input  logic [4:0] sector_number,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] gcr_byte,
  output logic       run_last,
  output logic       sector_done
);
  import gse_pkg::*;

  cmd_t front_cmd;
  cmd_t head_cmd;
  logic front_valid;
  logic cmd_empty;
  logic cmd_pop;
  logic accept;

  assign accept = push && !full;

  gse_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .accept        (accept),
    .data_byte     (data_byte),
    .track_number  (track_number),
    .sector_number (sector_number),
    .cmd_valid     (front_valid),
    .cmd           (front_cmd)
  );

  gse_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (front_valid),
    .wr_data (front_cmd),
    .full    (full),
    .rd_en   (cmd_pop),
    .rd_data (head_cmd),
    .empty   (cmd_empty)
  );

  gse_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_empty   (cmd_empty),
    .cmd_head    (head_cmd),
    .cmd_pop     (cmd_pop),
    .pop         (pop),
    .empty       (empty),
    .gcr_byte    (gcr_byte),
    .run_last    (run_last),
    .sector_done (sector_done)
  );

endmodule
